### hdl/rpt_pkg.sv
package rpt_pkg;

   // default sizes
   localparam int REGIONS_DEF   = 64;
   localparam int ADDR_BITS_DEF = 32;
   // widest slot index the chain carries (REGIONS up to 256)
   localparam int IDX_BITS      = 8;

   localparam logic [31:0] GEN_RETIRED = 32'hFFFF_FFFF;
   localparam logic [31:0] LEASE_MAX   = 32'hFFFF_FFFF;

   // operation codes
   localparam logic [2:0] MODE_REGISTER = 3'd0;
   localparam logic [2:0] MODE_REVOKE   = 3'd1;
   localparam logic [2:0] MODE_LEASE    = 3'd2;
   localparam logic [2:0] MODE_END      = 3'd3;
   localparam logic [2:0] MODE_SET_WIN  = 3'd4;
   localparam logic [2:0] MODE_CHECK    = 3'd5;

   // status codes
   localparam logic [3:0] ST_OK          = 4'd0;
   localparam logic [3:0] ST_BAD_HANDLE  = 4'd1;
   localparam logic [3:0] ST_BAD_LENGTH  = 4'd2;
   localparam logic [3:0] ST_WRAP        = 4'd3;
   localparam logic [3:0] ST_OVERLAP     = 4'd4;
   localparam logic [3:0] ST_FULL        = 4'd5;
   localparam logic [3:0] ST_WRONG_KIND  = 4'd6;
   localparam logic [3:0] ST_LEASED      = 4'd7;
   localparam logic [3:0] ST_LEASE_LIMIT = 4'd8;
   localparam logic [3:0] ST_NO_LEASE    = 4'd9;
   localparam logic [3:0] ST_NOT_FOUND   = 4'd10;
   localparam logic [3:0] ST_RIGHTS      = 4'd11;
   localparam logic [3:0] ST_WINDOW      = 4'd12;

   typedef struct packed {
      logic [2:0]  mode;
      logic [31:0] addr;
      logic [31:0] length;
      logic [31:0] window;
      logic [7:0]  rights;
      logic        kind;
      logic [5:0]  slot;
      logic [31:0] generation;
   } req_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [5:0]  out_slot;
      logic [31:0] out_generation;
   } rsp_type;

   // partial result handed from cell to cell
   typedef struct packed {
      logic                hit;
      logic                overlap;
      logic [IDX_BITS-1:0] idx;
      logic [3:0]          status;
      logic [31:0]         gen;
   } acc_type;

   // update broadcast to the cells at the end of a scan
   typedef struct packed {
      logic                en;
      logic [2:0]          mode;
      logic [IDX_BITS-1:0] idx;
   } commit_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

endpackage

### hdl/rpt_cell.sv
module rpt_cell import rpt_pkg::*; #(
   parameter int IDX       = 0,
   parameter int ADDR_BITS = ADDR_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req,
   input  logic       valid_in,
   input  acc_type    acc_in,
   input  commit_type commit,
   output logic       valid_out,
   output acc_type    acc_out
);

   localparam logic [64:0] AMASK = (65'd1 << ADDR_BITS) - 65'd1;

   logic [31:0] base_ff, cap_ff, win_ff, lease_ff, gen_ff;
   logic [7:0]  rights_ff;
   logic        ext_ff, alive_ff, valid_ff;
   acc_type     acc_ff, acc_in_d;

   logic [31:0] addr_m, off;
   logic [32:0] end_here, end_req, win_end, left;
   logic        handle_ok, contains, free, sel;
   logic [3:0]  st;

   // per-slot compare against the request
   always_comb begin
      addr_m    = req.addr & AMASK[31:0];
      off       = addr_m - base_ff;
      end_here  = {1'b0, base_ff} + {1'b0, cap_ff};
      end_req   = {1'b0, addr_m} + {1'b0, req.length};
      win_end   = {1'b0, base_ff} + {1'b0, req.length};
      left      = {1'b0, base_ff} + {1'b0, win_ff} - {1'b0, addr_m};
      handle_ok = alive_ff && (32'(req.slot) == 32'(IDX)) && (gen_ff == req.generation);
      contains  = alive_ff && (addr_m >= base_ff) && (off < cap_ff);
      free      = !alive_ff && (gen_ff != GEN_RETIRED);
      sel       = 1'b0;
      st        = ST_OK;
      case (req.mode)
         MODE_REGISTER: begin
            sel = free;
         end
         MODE_REVOKE: begin
            sel = handle_ok;
            if (ext_ff != req.kind)         st = ST_WRONG_KIND;
            else if (lease_ff != 32'd0)     st = ST_LEASED;
         end
         MODE_LEASE: begin
            sel = handle_ok;
            if (lease_ff == LEASE_MAX) st = ST_LEASE_LIMIT;
         end
         MODE_END: begin
            sel = handle_ok;
            if (lease_ff == 32'd0) st = ST_NO_LEASE;
         end
         MODE_SET_WIN: begin
            sel = handle_ok;
            if (req.length > cap_ff)             st = ST_BAD_LENGTH;
            else if ({32'd0, win_end} > AMASK)  st = ST_WRAP;
         end
         MODE_CHECK: begin
            sel = contains;
            if ((rights_ff & req.rights) != req.rights) st = ST_RIGHTS;
            else if (off >= win_ff)                      st = ST_WINDOW;
            else if (left < {1'b0, req.length})          st = ST_WINDOW;
         end
         default: begin
            sel = 1'b0;
         end
      endcase
   end

   // merge into the passing word
   always_comb begin
      acc_in_d = acc_in;
      if (req.mode == MODE_REGISTER && alive_ff &&
          {1'b0, addr_m} < end_here && {1'b0, base_ff} < end_req)
         acc_in_d.overlap = 1'b1;
      if (!acc_in.hit && sel) begin
         acc_in_d.hit    = 1'b1;
         acc_in_d.idx    = IDX_BITS'(IDX);
         acc_in_d.status = st;
         acc_in_d.gen    = (req.mode == MODE_REGISTER) ? gen_ff + 32'd1 : gen_ff;
      end
   end

   // chain stage
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      acc_ff <= acc_in_d;
   end

   // slot state update
   always_ff @(posedge clock) begin
      if (reset) begin
         alive_ff <= 1'b0;
         gen_ff   <= 32'd0;
      end else if (commit.en && commit.idx == IDX_BITS'(IDX)) begin
         case (commit.mode)
            MODE_REGISTER: begin
               base_ff   <= addr_m;
               cap_ff    <= req.length;
               win_ff    <= req.window;
               rights_ff <= req.rights;
               ext_ff    <= req.kind;
               lease_ff  <= 32'd0;
               gen_ff    <= gen_ff + 32'd1;
               alive_ff  <= 1'b1;
            end
            MODE_REVOKE:  alive_ff <= 1'b0;
            MODE_LEASE:   lease_ff <= lease_ff + 32'd1;
            MODE_END:     lease_ff <= lease_ff - 32'd1;
            MODE_SET_WIN: win_ff   <= req.length;
            default:      ;
         endcase
      end
   end

   assign valid_out = valid_ff;
   assign acc_out   = acc_ff;

endmodule

### hdl/region_protection_table.sv
// channel  | direction | ports
// req      | in        | req_valid, req_ready, req_data (req_type)
// rsp      | out       | rsp_valid, rsp_ready, rsp_data (rsp_type)
//
// every operation sends one word down a chain of REGIONS slot cells, one cell
// per cycle; its result is registered, then passed to the response register.
// the chain end applies the update to the selected slot in the same cycle.
// reset clears all slots to dead with generation zero, at once.
// one item in flight; a result waiting on rsp_ready does not block the accept.
module region_protection_table import rpt_pkg::*; #(
   parameter int REGIONS   = REGIONS_DEF,
   parameter int ADDR_BITS = ADDR_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam logic [64:0] AMASK = (65'd1 << ADDR_BITS) - 65'd1;

   state_type  state_ff, state_in;
   req_type    req_ff;
   rsp_type    res_ff, res_in, rsp_data_ff;
   logic       rsp_valid_ff, start_ff;
   commit_type commit;

   logic    vld [REGIONS+1];
   acc_type acc [REGIONS+1];

   logic [31:0] addr_m;
   logic [32:0] reg_end;

   assign vld[0] = start_ff;
   assign acc[0] = '0;

   // slot cells
   for (genvar k = 0; k < REGIONS; k++) begin : g_cell
      rpt_cell #(.IDX(k), .ADDR_BITS(ADDR_BITS)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .req       (req_ff),
         .valid_in  (vld[k]),
         .acc_in    (acc[k]),
         .commit    (commit),
         .valid_out (vld[k+1]),
         .acc_out   (acc[k+1])
      );
   end

   // final status and slot update
   always_comb begin
      addr_m   = req_ff.addr & AMASK[31:0];
      reg_end  = {1'b0, addr_m} + {1'b0, req_ff.length};
      res_in   = '0;
      commit   = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (vld[REGIONS]) begin
               state_in = ST_DONE;
               if (req_ff.mode == MODE_REGISTER) begin
                  if (req_ff.length == 32'd0 || req_ff.window > req_ff.length)
                     res_in.status = ST_BAD_LENGTH;
                  else if ({32'd0, reg_end} > AMASK) res_in.status = ST_WRAP;
                  else if (acc[REGIONS].overlap)     res_in.status = ST_OVERLAP;
                  else if (!acc[REGIONS].hit)        res_in.status = ST_FULL;
                  else begin
                     res_in.status         = ST_OK;
                     res_in.out_slot       = acc[REGIONS].idx[5:0];
                     res_in.out_generation = acc[REGIONS].gen;
                  end
               end else if (acc[REGIONS].hit) begin
                  res_in.status = acc[REGIONS].status;
                  if (req_ff.mode == MODE_CHECK) begin
                     res_in.out_slot       = acc[REGIONS].idx[5:0];
                     res_in.out_generation = acc[REGIONS].gen;
                  end
               end else begin
                  res_in.status = (req_ff.mode == MODE_CHECK) ? ST_NOT_FOUND
                                                              : ST_BAD_HANDLE;
               end
               commit.en   = (res_in.status == ST_OK) && (req_ff.mode != MODE_CHECK);
               commit.mode = req_ff.mode;
               commit.idx  = acc[REGIONS].idx;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         start_ff <= (state_ff == ST_IDLE) && req_valid;
         if (state_ff == ST_DONE && (!rsp_valid_ff || rsp_ready))
            rsp_valid_ff <= 1'b1;
         else if (rsp_ready)
            rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) req_ff <= req_data;
      if (state_ff == ST_SCAN && vld[REGIONS]) res_ff <= res_in;
      if (state_ff == ST_DONE && (!rsp_valid_ff || rsp_ready)) rsp_data_ff <= res_ff;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### hdl/rpt_checker.sv
module rpt_checker import rpt_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // status stays within the code list
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status <= ST_WINDOW)
      else $error("status code out of range");

   // one item at a time
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("accepted a word while busy");

   // no handle comes back on a failure without a hit region
   a_zero_gen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK && rsp_data.status != ST_RIGHTS &&
      rsp_data.status != ST_WINDOW |-> rsp_data.out_generation == 32'd0)
      else $error("handle returned on failure");

endmodule

bind region_protection_table rpt_checker u_rpt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
